// ===== sv/mmbs_pkg.sv =====
// shared types, codes and constants of the minute bar statistics block
`timescale 1ns / 1ps
package mmbs_pkg;

   localparam int NWORDS = 21;

   typedef logic [NWORDS-1:0][63:0] record_type;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   // word numbers inside a bin or record
   localparam logic [4:0] W_MSG_COUNT   = 5'd0;
   localparam logic [4:0] W_TIMESTAMP   = 5'd1;
   localparam logic [4:0] W_QUOTE_COUNT = 5'd2;
   localparam logic [4:0] W_MID_SUM     = 5'd3;
   localparam logic [4:0] W_MID_SQ_SUM  = 5'd4;
   localparam logic [4:0] W_MID_MIN     = 5'd5;
   localparam logic [4:0] W_MID_MAX     = 5'd6;
   localparam logic [4:0] W_SPREAD_SUM  = 5'd7;
   localparam logic [4:0] W_SPREAD_MIN  = 5'd8;
   localparam logic [4:0] W_SPREAD_MAX  = 5'd9;
   localparam logic [4:0] W_TRADE_COUNT = 5'd10;
   localparam logic [4:0] W_PRICE_SUM   = 5'd11;
   localparam logic [4:0] W_SIZE_SUM    = 5'd12;
   localparam logic [4:0] W_PS_SUM      = 5'd13;
   localparam logic [4:0] W_PPS_SUM     = 5'd14;
   localparam logic [4:0] W_BUY_VOL     = 5'd15;
   localparam logic [4:0] W_SELL_VOL    = 5'd16;
   localparam logic [4:0] W_SIZE_MIN    = 5'd17;
   localparam logic [4:0] W_SIZE_MAX    = 5'd18;
   localparam logic [4:0] W_L1_SUM      = 5'd19;
   localparam logic [4:0] W_TICK        = 5'd20;
   localparam logic [4:0] W_LAST        = 5'd20;

   localparam logic [1:0] FUNC_QUOTE    = 2'd0;
   localparam logic [1:0] FUNC_TRADE    = 2'd1;
   localparam logic [1:0] FUNC_READ_BIN = 2'd2;
   localparam logic [1:0] FUNC_READ_DAY = 2'd3;

   localparam logic [1:0] SIDE_BUY  = 2'd0;
   localparam logic [1:0] SIDE_SELL = 2'd1;

   localparam logic CSR_WINDOW_START = 1'b0;
   localparam logic CSR_WINDOW_END   = 1'b1;

   localparam logic [16:0] WINDOW_START_RESET = 17'd0;
   localparam logic [16:0] WINDOW_END_RESET   = 17'd36000;

   // t / 86400 as ((t >> 7) * DIV675_MUL) >> DIV675_SHIFT, exact for 25-bit operands
   localparam logic [25:0] DIV675_MUL   = 26'd50903317;
   localparam int          DIV675_SHIFT = 35;
   // x / 60 as (x * DIV60_MUL) >> DIV60_SHIFT, exact for 17-bit operands
   localparam logic [17:0] DIV60_MUL    = 18'd139811;
   localparam int          DIV60_SHIFT  = 23;
   localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
   localparam logic [6:0]  SEC_PER_MIN  = 7'd60;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] event_time;
      logic [7:0]  security;
      logic [23:0] bid_price;
      logic [23:0] ask_price;
      logic [23:0] bid_size;
      logic [23:0] ask_size;
      logic [15:0] tick_size;
      logic [23:0] trade_price;
      logic [23:0] trade_size;
      logic [1:0]  trade_side;
      logic [4:0]  stat_select;
   } item_type;

   // products and timestamp handed to the record update
   typedef struct packed {
      logic [49:0] mm;
      logic [47:0] ps;
      logic [63:0] ppps;
      logic [31:0] ts;
   } prod_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_DIV3,
      ST_READ,
      ST_UPDATE
   } state_type;

   function automatic record_type clear_record();
      record_type r;
      r = '0;
      r[W_MID_MIN]    = ALL_ONES;
      r[W_SPREAD_MIN] = ALL_ONES;
      r[W_SIZE_MIN]   = ALL_ONES;
      return r;
   endfunction

   localparam record_type CLEAR_REC = clear_record();

endpackage

// ===== sv/mmbs_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface mmbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] event_time;
   logic [7:0]  security;
   logic [23:0] bid_price;
   logic [23:0] ask_price;
   logic [23:0] bid_size;
   logic [23:0] ask_size;
   logic [15:0] tick_size;
   logic [23:0] trade_price;
   logic [23:0] trade_size;
   logic [1:0]  trade_side;
   logic [4:0]  stat_select;

   modport source (
      output valid, func, event_time, security, bid_price, ask_price, bid_size, ask_size,
      output tick_size, trade_price, trade_size, trade_side, stat_select,
      input  ready
   );
   modport sink (
      input  valid, func, event_time, security, bid_price, ask_price, bid_size, ask_size,
      input  tick_size, trade_price, trade_size, trade_side, stat_select,
      output ready
   );
endinterface

interface mmbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] stat_value;
   logic        read_ok;

   modport source (output valid, stat_value, read_ok, input ready);
   modport sink (input valid, stat_value, read_ok, output ready);
endinterface

// ===== sv/mmbs_rec_update.sv =====
// applies one quote or trade to a bin or day record
`timescale 1ns / 1ps
module mmbs_rec_update import mmbs_pkg::*; (
   input  record_type rec_old,
   input  item_type   item,
   input  prod_type   prod,
   output record_type rec_new
);

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ALL_ONES : s[63:0];
   endfunction

   function automatic logic [63:0] sat_add_signed(input logic [63:0] a,
                                                  input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if ((((a ^ b) & SIGN_BIT) == '0) && (((r ^ a) & SIGN_BIT) != '0)) begin
         r = (a[63]) ? SIGN_BIT : (SIGN_BIT - 64'd1);
      end
      return r;
   endfunction

   logic [24:0] mid2;
   logic [24:0] sp25;
   logic [63:0] sp;
   logic [24:0] l1_sum;
   logic [63:0] mid64;
   logic [63:0] size64;

   always_comb begin
      mid2   = {1'b0, item.bid_price} + {1'b0, item.ask_price};
      sp25   = {1'b0, item.ask_price} - {1'b0, item.bid_price};
      sp     = {{39{sp25[24]}}, sp25};
      l1_sum = {1'b0, item.bid_size} + {1'b0, item.ask_size};
      mid64  = {39'b0, mid2};
      size64 = {40'b0, item.trade_size};

      rec_new = rec_old;
      rec_new[W_MSG_COUNT] = sat_add(rec_old[W_MSG_COUNT], 64'd1);
      rec_new[W_TIMESTAMP] = {32'b0, prod.ts};
      rec_new[W_TICK]      = {48'b0, item.tick_size};

      if (item.func == FUNC_QUOTE) begin
         rec_new[W_QUOTE_COUNT] = sat_add(rec_old[W_QUOTE_COUNT], 64'd1);
         rec_new[W_MID_SUM]     = sat_add(rec_old[W_MID_SUM], mid64);
         rec_new[W_MID_SQ_SUM]  = sat_add(rec_old[W_MID_SQ_SUM], {14'b0, prod.mm});
         if (mid64 < rec_old[W_MID_MIN]) begin
            rec_new[W_MID_MIN] = mid64;
         end
         if (mid64 > rec_old[W_MID_MAX]) begin
            rec_new[W_MID_MAX] = mid64;
         end
         rec_new[W_SPREAD_SUM] = sat_add_signed(rec_old[W_SPREAD_SUM], sp);
         // minimum spread kept with its top bit flipped so it compares unsigned
         if ((sp ^ SIGN_BIT) < rec_old[W_SPREAD_MIN]) begin
            rec_new[W_SPREAD_MIN] = sp ^ SIGN_BIT;
         end
         if ($signed(sp) > $signed(rec_old[W_SPREAD_MAX])) begin
            rec_new[W_SPREAD_MAX] = sp;
         end
         rec_new[W_L1_SUM] = sat_add(rec_old[W_L1_SUM], {40'b0, l1_sum[24:1]});
      end else begin
         rec_new[W_TRADE_COUNT] = sat_add(rec_old[W_TRADE_COUNT], 64'd1);
         rec_new[W_PRICE_SUM]   = sat_add(rec_old[W_PRICE_SUM], {40'b0, item.trade_price});
         rec_new[W_SIZE_SUM]    = sat_add(rec_old[W_SIZE_SUM], size64);
         rec_new[W_PS_SUM]      = sat_add(rec_old[W_PS_SUM], {16'b0, prod.ps});
         rec_new[W_PPS_SUM]     = sat_add(rec_old[W_PPS_SUM], prod.ppps);
         if (item.trade_side == SIDE_BUY) begin
            rec_new[W_BUY_VOL] = sat_add(rec_old[W_BUY_VOL], size64);
         end else if (item.trade_side == SIDE_SELL) begin
            rec_new[W_SELL_VOL] = sat_add(rec_old[W_SELL_VOL], size64);
         end
         if (size64 < rec_old[W_SIZE_MIN]) begin
            rec_new[W_SIZE_MIN] = size64;
         end
         if (size64 > rec_old[W_SIZE_MAX]) begin
            rec_new[W_SIZE_MAX] = size64;
         end
      end
   end

endmodule

// ===== sv/market_minute_bar_statistics.sv =====
// Per-minute and whole-day bar statistics per security.
// req channel: quote updates, trade prints and reads; one transfer is taken
// when req.valid and req.ready are high. rsp channel: one transfer per read,
// carrying stat_value and read_ok; quotes and trades give no response.
// csr port: csr_we writes csr_wdata into window_start (index 0) or
// window_end (index 1); write only while the block is idle.
// After a transfer req.ready stays low until the item is through, so the
// block takes no new item before the last is done: time-of-day and
// minute arithmetic by reciprocal multipliers (DIV1 to DIV3), synchronous
// memory read, update and write-back, then idle, which takes the next item.
// A read response is loaded into its register in the update state.
// The state lives in two row-wide memories (minute bins, day records); an
// item reads and writes its rows before the next is taken, so no accesses
// overlap. After reset a clearing pass writes every bin row, one a cycle;
// req.ready stays low meanwhile, csr writes are taken. A stalled response
// is held; events carry on, but a later read waits in its update state
// until the held response is taken.
`timescale 1ns / 1ps
module market_minute_bar_statistics import mmbs_pkg::*; #(
   parameter int SECURITY_COUNT = 8,
   parameter int MINUTE_BINS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   mmbs_req_if.sink    req,
   mmbs_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int BIN_ROWS = SECURITY_COUNT * MINUTE_BINS;
   localparam int ADDR_W   = (BIN_ROWS > 1) ? $clog2(BIN_ROWS) : 1;
   localparam int SEC_W    = (SECURITY_COUNT > 1) ? $clog2(SECURITY_COUNT) : 1;
   localparam int MIN_W    = (MINUTE_BINS > 1) ? $clog2(MINUTE_BINS) : 1;

   record_type bin_mem [BIN_ROWS];
   record_type day_mem [SECURITY_COUNT];

   state_type   state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [16:0] ws_ff, we_ff;
   item_type    item_ff, item_in;

   logic [15:0] q86_ff;
   logic [47:0] pp_ff;
   logic [16:0] tod_ff;
   logic [47:0] pphi_ff, pplo_ff;
   logic [49:0] mm_ff;
   logic [47:0] ps_ff;
   logic [10:0] tq_ff;
   logic [11:0] minute_ff;
   logic [63:0] ppps_ff;
   logic        do_evt_ff, do_bin_ff, rec_ok_ff;
   logic [31:0] ts_ff;
   logic [ADDR_W-1:0] bin_addr_ff, bin_addr_in;
   record_type  bin_q_ff, day_q_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] value_ff;
   logic        ok_ff;

   logic [50:0] q86_prod;
   logic [32:0] day_secs;
   logic [31:0] tod_full;
   logic [24:0] mid2;
   logic [34:0] tq_prod, min_prod;
   logic [16:0] diff;
   logic [71:0] pp_full;
   logic        sec_ok, in_win, quote_ok, in_bins, is_event;
   logic [SEC_W-1:0] sec_idx;
   logic [16:0] tq_secs;

   logic        accept, load_rsp, bin_we, day_we, clr_last, clr_day;
   prod_type    prod;
   record_type  bin_new, day_new, rd_rec;
   logic [63:0] rd_word, value_in;
   logic        ok_in;

   assign item_in = '{func: req.func, event_time: req.event_time, security: req.security,
                      bid_price: req.bid_price, ask_price: req.ask_price,
                      bid_size: req.bid_size, ask_size: req.ask_size,
                      tick_size: req.tick_size, trade_price: req.trade_price,
                      trade_size: req.trade_size, trade_side: req.trade_side,
                      stat_select: req.stat_select};

   assign sec_idx  = item_ff.security[SEC_W-1:0];
   assign is_event = !item_ff.func[1];
   assign clr_last = (clr_ff == ADDR_W'(BIN_ROWS - 1));
   assign clr_day  = ({1'b0, clr_ff} < (ADDR_W + 1)'(SECURITY_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req.valid) state_in = ST_DIV1;
         ST_DIV1:   state_in = ST_DIV2;
         ST_DIV2:   state_in = ST_DIV3;
         ST_DIV3:   state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (is_event || !rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready = 1'b0;
      load_rsp  = 1'b0;
      bin_we    = 1'b0;
      day_we    = 1'b0;
      clr_in    = clr_ff;
      case (state_ff)
         ST_CLEAR:  clr_in = clr_ff + ADDR_W'(1);
         ST_IDLE:   req.ready = 1'b1;
         ST_UPDATE: begin
            bin_we   = do_bin_ff;
            day_we   = do_evt_ff;
            load_rsp = !is_event && (!rsp_valid_ff || rsp.ready);
         end
         default:   clr_in = clr_ff;
      endcase
   end

   assign accept = req.valid && req.ready;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ws_ff        <= WINDOW_START_RESET;
         we_ff        <= WINDOW_END_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_WINDOW_START) ws_ff <= csr_wdata;
            else we_ff <= csr_wdata;
         end
      end
   end

   // datapath arithmetic
   always_comb begin
      q86_prod = 51'(item_ff.event_time[31:7]) * 51'(DIV675_MUL);
      day_secs = 33'(q86_ff) * 33'(SEC_PER_DAY);
      tod_full = item_ff.event_time - day_secs[31:0];
      mid2     = {1'b0, item_ff.bid_price} + {1'b0, item_ff.ask_price};
      tq_prod  = 35'(tod_ff) * 35'(DIV60_MUL);
      diff     = tod_ff - ws_ff;
      min_prod = 35'(diff) * 35'(DIV60_MUL);
      pp_full  = {pphi_ff, 24'b0} + 72'(pplo_ff);
      sec_ok   = {1'b0, item_ff.security} < 9'(SECURITY_COUNT);
      in_win   = (tod_ff > ws_ff) && (tod_ff < we_ff);
      quote_ok = (item_ff.func != FUNC_QUOTE) ||
                 ((item_ff.bid_size != '0) && (item_ff.ask_size != '0));
      in_bins  = min_prod[34:23] < 12'(MINUTE_BINS);
      tq_secs  = 17'(tq_ff) * 17'(SEC_PER_MIN);
      bin_addr_in = ADDR_W'(sec_idx) * ADDR_W'(MINUTE_BINS) +
                    ADDR_W'(minute_ff[MIN_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
      case (state_ff)
         ST_DIV1: begin
            q86_ff <= q86_prod[DIV675_SHIFT +: 16];
            pp_ff  <= 48'(item_ff.trade_price) * 48'(item_ff.trade_price);
         end
         ST_DIV2: begin
            tod_ff  <= tod_full[16:0];
            pphi_ff <= 48'(pp_ff[47:24]) * 48'(item_ff.trade_size);
            pplo_ff <= 48'(pp_ff[23:0]) * 48'(item_ff.trade_size);
            mm_ff   <= 50'(mid2) * 50'(mid2);
            ps_ff   <= 48'(item_ff.trade_price) * 48'(item_ff.trade_size);
         end
         ST_DIV3: begin
            tq_ff     <= tq_prod[DIV60_SHIFT +: 11];
            minute_ff <= min_prod[DIV60_SHIFT +: 12];
            ppps_ff   <= (pp_full[71:64] != '0) ? ALL_ONES : pp_full[63:0];
            do_evt_ff <= is_event && sec_ok && in_win && quote_ok;
            do_bin_ff <= is_event && sec_ok && in_win && quote_ok && in_bins;
            rec_ok_ff <= sec_ok && ((item_ff.func == FUNC_READ_DAY) ||
                                    ((tod_ff >= ws_ff) && in_bins));
         end
         ST_READ: begin
            // time rounded down to a minute: t - (tod mod 60)
            ts_ff       <= item_ff.event_time - 32'(tod_ff - tq_secs);
            bin_addr_ff <= bin_addr_in;
         end
         default: begin
         end
      endcase
   end

   // memories: one read and one write per row
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         bin_q_ff <= bin_mem[bin_addr_in];
         day_q_ff <= day_mem[sec_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         bin_mem[clr_ff] <= CLEAR_REC;
      end else if (bin_we) begin
         bin_mem[bin_addr_ff] <= bin_new;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         if (clr_day) day_mem[clr_ff[SEC_W-1:0]] <= CLEAR_REC;
      end else if (day_we) begin
         day_mem[sec_idx] <= day_new;
      end
   end

   assign prod = '{mm: mm_ff, ps: ps_ff, ppps: ppps_ff, ts: ts_ff};

   mmbs_rec_update u_bin_update (
      .rec_old (bin_q_ff),
      .item    (item_ff),
      .prod    (prod),
      .rec_new (bin_new)
   );

   mmbs_rec_update u_day_update (
      .rec_old (day_q_ff),
      .item    (item_ff),
      .prod    (prod),
      .rec_new (day_new)
   );

   // read response
   always_comb begin
      rd_rec   = (item_ff.func == FUNC_READ_DAY) ? day_q_ff : bin_q_ff;
      rd_word  = '0;
      value_in = '0;
      if (item_ff.stat_select <= W_LAST) rd_word = rd_rec[item_ff.stat_select];
      if (rec_ok_ff && (item_ff.stat_select <= W_LAST)) begin
         value_in = rd_word;
         if ((item_ff.stat_select == W_MID_MIN) || (item_ff.stat_select == W_SIZE_MIN)) begin
            if (rd_word == ALL_ONES) value_in = '0;
         end else if (item_ff.stat_select == W_SPREAD_MIN) begin
            value_in = (rd_word == ALL_ONES) ? '0 : (rd_word ^ SIGN_BIT);
         end
      end
      ok_in = rec_ok_ff && (rd_rec[W_MSG_COUNT] != '0);
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         value_ff <= value_in;
         ok_ff    <= ok_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.stat_value = value_ff;
   assign rsp.read_ok    = ok_ff;

endmodule

// ===== sv/mmbs_checker.sv =====
// port-level checks of the minute bar statistics block, bound to the top level
`timescale 1ns / 1ps
module mmbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_stat_value,
   input logic        rsp_read_ok
);

   // no response survives reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stat_value) && $stable(rsp_read_ok))
      else $error("stalled response changed");

   // one item at a time: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // an empty or invalid bin reads as zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_ok |-> rsp_stat_value == 64'd0)
      else $error("nonzero value from empty record");

endmodule

bind market_minute_bar_statistics mmbs_checker u_mmbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_stat_value (rsp.stat_value),
   .rsp_read_ok    (rsp.read_ok)
);

// ===== test/market_minute_bar_statistics_tb.sv =====
// self-checking testbench for the minute bar statistics block
`timescale 1ns / 1ps
module market_minute_bar_statistics_tb import mmbs_pkg::*; ;

   localparam int SECURITIES = 8;
   localparam int BINS       = 1024;
   localparam logic [31:0] T_BASE = 32'd86400600;   // day 1000, second 600

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_WINDOW_START;
   logic [16:0] csr_wdata = '0;

   mmbs_req_if req ();
   mmbs_rsp_if rsp ();

   market_minute_bar_statistics #(
      .SECURITY_COUNT(SECURITIES),
      .MINUTE_BINS(BINS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted state of the bar memories and window
   record_type  bin_rec [int];
   record_type  day_rec [SECURITIES];
   logic [16:0] win_start, win_end;

   logic [64:0] expected_reads [$];   // {read_ok, stat_value}
   int mismatches, checked, n_quotes, n_trades, n_reads;
   int send_idle_pct, recv_stall_pct;

   // recently counted events, reused as read addresses
   logic [31:0] recent_time [$];
   logic [7:0]  recent_sec [$];

   // directed stimulus table
   item_type    dir_items [$];
   logic [64:0] dir_res [$];
   bit          dir_typed [$];

   function automatic void add_row(item_type it, bit typed, logic [64:0] res);
      dir_items = {dir_items, it};
      dir_typed = {dir_typed, typed};
      dir_res   = {dir_res, res};
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      return (r < a) ? ALL_ONES : r;
   endfunction

   function automatic logic [63:0] add_sat_signed(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (((a ^ b) & SIGN_BIT) == 0 && ((r ^ a) & SIGN_BIT) != 0)
         return (a & SIGN_BIT) ? SIGN_BIT : SIGN_BIT - 64'd1;
      return r;
   endfunction

   function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (p[127:64] != 0) ? ALL_ONES : p[63:0];
   endfunction

   function automatic record_type quote_update(record_type r, item_type it, logic [63:0] ts);
      logic [63:0] mid2, spread, depth;
      mid2   = {40'd0, it.bid_price} + {40'd0, it.ask_price};
      spread = {40'd0, it.ask_price} - {40'd0, it.bid_price};
      depth  = ({40'd0, it.bid_size} + {40'd0, it.ask_size}) >> 1;
      r[W_MSG_COUNT]   = add_sat(r[W_MSG_COUNT], 64'd1);
      r[W_TIMESTAMP]   = ts;
      r[W_QUOTE_COUNT] = add_sat(r[W_QUOTE_COUNT], 64'd1);
      r[W_MID_SUM]     = add_sat(r[W_MID_SUM], mid2);
      r[W_MID_SQ_SUM]  = add_sat(r[W_MID_SQ_SUM], mid2 * mid2);
      if (mid2 < r[W_MID_MIN]) r[W_MID_MIN] = mid2;
      if (mid2 > r[W_MID_MAX]) r[W_MID_MAX] = mid2;
      r[W_SPREAD_SUM]  = add_sat_signed(r[W_SPREAD_SUM], spread);
      // minimum spread is held with the sign bit flipped
      if ((spread ^ SIGN_BIT) < r[W_SPREAD_MIN]) r[W_SPREAD_MIN] = spread ^ SIGN_BIT;
      if ((spread ^ SIGN_BIT) > (r[W_SPREAD_MAX] ^ SIGN_BIT)) r[W_SPREAD_MAX] = spread;
      r[W_L1_SUM]      = add_sat(r[W_L1_SUM], depth);
      r[W_TICK]        = {48'd0, it.tick_size};
      return r;
   endfunction

   function automatic record_type trade_update(record_type r, item_type it, logic [63:0] ts);
      logic [63:0] px, qty;
      px  = {40'd0, it.trade_price};
      qty = {40'd0, it.trade_size};
      r[W_MSG_COUNT]   = add_sat(r[W_MSG_COUNT], 64'd1);
      r[W_TIMESTAMP]   = ts;
      r[W_TRADE_COUNT] = add_sat(r[W_TRADE_COUNT], 64'd1);
      r[W_PRICE_SUM]   = add_sat(r[W_PRICE_SUM], px);
      r[W_SIZE_SUM]    = add_sat(r[W_SIZE_SUM], qty);
      r[W_PS_SUM]      = add_sat(r[W_PS_SUM], px * qty);
      r[W_PPS_SUM]     = add_sat(r[W_PPS_SUM], mul_sat(px * px, qty));
      if (it.trade_side == SIDE_BUY)
         r[W_BUY_VOL] = add_sat(r[W_BUY_VOL], qty);
      else if (it.trade_side == SIDE_SELL)
         r[W_SELL_VOL] = add_sat(r[W_SELL_VOL], qty);
      if (qty < r[W_SIZE_MIN]) r[W_SIZE_MIN] = qty;
      if (qty > r[W_SIZE_MAX]) r[W_SIZE_MAX] = qty;
      r[W_TICK]        = {48'd0, it.tick_size};
      return r;
   endfunction

   // updates the predicted state; returns 1 and the read result for reads
   function automatic bit predict_bar(item_type it, output logic [64:0] res);
      logic [63:0] tod, ts, minute, v;
      record_type  r;
      bit          found;
      int          key;
      tod = {32'd0, it.event_time} % 64'd86400;
      ts  = {32'd0, it.event_time} - ({32'd0, it.event_time} % 64'd60);
      res = '0;
      if (it.func == FUNC_QUOTE || it.func == FUNC_TRADE) begin
         if (it.security >= SECURITIES) return 0;
         if (!(tod > win_start && tod < win_end)) return 0;
         if (it.func == FUNC_QUOTE && (it.bid_size == 0 || it.ask_size == 0)) return 0;
         minute = (tod - win_start) / 64'd60;
         key = int'(it.security) * BINS + int'(minute);
         if (minute < BINS) begin
            if (!bin_rec.exists(key)) bin_rec[key] = CLEAR_REC;
            bin_rec[key] = (it.func == FUNC_QUOTE) ? quote_update(bin_rec[key], it, ts)
                                                   : trade_update(bin_rec[key], it, ts);
         end
         day_rec[it.security] = (it.func == FUNC_QUOTE) ?
            quote_update(day_rec[it.security], it, ts) :
            trade_update(day_rec[it.security], it, ts);
         recent_time = {recent_time, it.event_time};
         recent_sec  = {recent_sec, it.security};
         if (recent_time.size() > 40) begin
            void'(recent_time.pop_front());
            void'(recent_sec.pop_front());
         end
         return 0;
      end
      found = 0;
      r = CLEAR_REC;
      if (it.security < SECURITIES) begin
         if (it.func == FUNC_READ_DAY) begin
            r = day_rec[it.security];
            found = 1;
         end else if (tod >= win_start) begin
            minute = (tod - win_start) / 64'd60;
            if (minute < BINS) begin
               key = int'(it.security) * BINS + int'(minute);
               if (bin_rec.exists(key)) r = bin_rec[key];
               found = 1;
            end
         end
      end
      v = '0;
      if (found && it.stat_select <= W_LAST) begin
         v = r[it.stat_select];
         if (it.stat_select == W_MID_MIN || it.stat_select == W_SIZE_MIN) begin
            if (v == ALL_ONES) v = '0;
         end else if (it.stat_select == W_SPREAD_MIN) begin
            v = (v == ALL_ONES) ? '0 : (v ^ SIGN_BIT);
         end
      end
      res = {found && r[W_MSG_COUNT] != 0, v};
      return 1;
   endfunction

   function automatic item_type blank_item(logic [1:0] f, logic [31:0] t, logic [7:0] s,
                                           logic [4:0] sel);
      item_type it;
      it = '0;
      it.func = f;
      it.event_time = t;
      it.security = s;
      it.tick_size = 16'd1;
      it.stat_select = sel;
      return it;
   endfunction

   // sender: one transfer, with random gaps before it
   task automatic send_item(item_type it, bit typed, logic [64:0] typed_res);
      logic [64:0] res;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid       = 1'b1;
      req.func        = it.func;
      req.event_time  = it.event_time;
      req.security    = it.security;
      req.bid_price   = it.bid_price;
      req.ask_price   = it.ask_price;
      req.bid_size    = it.bid_size;
      req.ask_size    = it.ask_size;
      req.tick_size   = it.tick_size;
      req.trade_price = it.trade_price;
      req.trade_size  = it.trade_size;
      req.trade_side  = it.trade_side;
      req.stat_select = it.stat_select;
      do @(posedge clock); while (!req.ready);
      if (predict_bar(it, res)) begin
         expected_reads = {expected_reads, (typed ? typed_res : res)};
         n_reads++;
      end else if (it.func == FUNC_QUOTE) begin
         n_quotes++;
      end else begin
         n_trades++;
      end
   endtask

   task automatic drain_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      // the last event may still be in its update cycles
      repeat (12) @(posedge clock);
   endtask

   task automatic write_window(logic [16:0] ws, logic [16:0] we);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_WINDOW_START;
      csr_wdata = ws;
      @(negedge clock);
      csr_index = CSR_WINDOW_END;
      csr_wdata = we;
      @(negedge clock);
      csr_we = 1'b0;
      win_start = ws;
      win_end = we;
   endtask

   function automatic logic [23:0] rand_value24();
      case ($urandom_range(7))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic item_type random_item();
      item_type    it;
      logic [31:0] tod;
      int          k, lo, hi;
      it = '0;
      it.func = 2'($urandom_range(3));
      it.security = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      lo = win_start;
      hi = (win_end > win_start) ? win_end : win_start;
      if (hi > 86399) hi = 86399;
      tod = ($urandom_range(6) == 0) ? $urandom_range(86399) : $urandom_range(hi, lo);
      it.event_time = 32'($urandom_range(49709)) * 32'd86400 + tod;
      if ($urandom_range(19) == 0) it.event_time = $urandom;
      if (it.func >= FUNC_READ_BIN && recent_time.size() != 0 && $urandom_range(3) != 0) begin
         k = $urandom_range(recent_time.size() - 1);
         it.event_time = recent_time[k];
         it.security = recent_sec[k];
      end
      it.bid_price = rand_value24();
      it.ask_price = ($urandom_range(4) == 0) ? rand_value24()
                                              : it.bid_price + 24'($urandom_range(50));
      it.bid_size = ($urandom_range(9) == 0) ? '0 : rand_value24() | 24'd1;
      it.ask_size = ($urandom_range(9) == 0) ? '0 : rand_value24() | 24'd1;
      it.tick_size = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
      it.trade_price = rand_value24();
      it.trade_size = rand_value24();
      it.trade_side = 2'($urandom_range(3));
      it.stat_select = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(20));
      return it;
   endfunction

   // receiver stalls
   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      logic [64:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: stat_value %h read_ok %b",
                        rsp.stat_value, rsp.read_ok);
         end else begin
            want = expected_reads.pop_front();
            checked++;
            if (rsp.stat_value !== want[63:0] || rsp.read_ok !== want[64]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: stat_value %h read_ok %b, expected %h %b",
                           rsp.stat_value, rsp.read_ok, want[63:0], want[64]);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("timeout with %0d responses outstanding", expected_reads.size());
      $display("market_minute_bar_statistics_tb NOT OK");
      $finish;
   end

   initial begin
      item_type    it;
      int          phase_ws [6] = '{0, 0, 86399, 34200, 100, 0};
      int          phase_we [6] = '{36000, 86400, 86400, 57600, 30000, 0};
      int          phase_mode [6] = '{0, 1, 2, 3, 0, 1};
      req.valid = 1'b0;
      req.func = FUNC_QUOTE;
      req.event_time = '0;
      req.security = '0;
      req.bid_price = '0;
      req.ask_price = '0;
      req.bid_size = '0;
      req.ask_size = '0;
      req.tick_size = 16'd1;
      req.trade_price = '0;
      req.trade_size = '0;
      req.trade_side = SIDE_BUY;
      req.stat_select = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      win_start = WINDOW_START_RESET;
      win_end = WINDOW_END_RESET;
      foreach (day_rec[i]) day_rec[i] = CLEAR_REC;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows: values known after reset are typed in
      add_row(blank_item(FUNC_READ_BIN, T_BASE, 8'd0, W_MID_MIN), 1'b1, 65'd0);
      add_row(blank_item(FUNC_READ_DAY, T_BASE, 8'd200, W_MSG_COUNT), 1'b1, 65'd0);
      add_row(blank_item(FUNC_READ_DAY, T_BASE, 8'd0, 5'd31), 1'b1, 65'd0);
      it = blank_item(FUNC_QUOTE, T_BASE, 8'd0, '0);
      it.ask_price = 24'hFFFFFF; it.bid_size = 24'hFFFFFF; it.ask_size = 24'hFFFFFF;
      it.tick_size = 16'hFFFF;
      add_row(it, 1'b0, 65'd0);
      // crossed quote
      it = blank_item(FUNC_QUOTE, T_BASE + 1, 8'd0, '0);
      it.bid_price = 24'hFFFFFF; it.bid_size = 24'd1; it.ask_size = 24'd1;
      add_row(it, 1'b0, 65'd0);
      // one-sided quote is dropped
      it = blank_item(FUNC_QUOTE, T_BASE + 2, 8'd0, '0);
      it.ask_size = 24'd5; it.bid_price = 24'd7;
      add_row(it, 1'b0, 65'd0);
      it = blank_item(FUNC_TRADE, T_BASE + 3, 8'd0, '0);
      it.trade_price = 24'hFFFFFF; it.trade_size = 24'hFFFFFF; it.trade_side = SIDE_BUY;
      add_row(it, 1'b0, 65'd0);
      it.trade_side = SIDE_SELL;
      add_row(it, 1'b0, 65'd0);
      it = blank_item(FUNC_TRADE, T_BASE + 4, 8'd0, '0);
      it.trade_side = 2'd2;
      add_row(it, 1'b0, 65'd0);
      it.trade_side = 2'd3; it.trade_size = 24'd9; it.trade_price = 24'd3;
      add_row(it, 1'b0, 65'd0);
      // out-of-range security and the window edges are dropped
      it = blank_item(FUNC_TRADE, T_BASE, 8'd255, '0);
      it.trade_size = 24'd1;
      add_row(it, 1'b0, 65'd0);
      it.security = 8'd7; it.event_time = 32'd86400000;
      add_row(it, 1'b0, 65'd0);
      it.event_time = 32'd86400000 + 32'd36000;
      add_row(it, 1'b0, 65'd0);
      begin
         logic [4:0] sels [10] = '{W_MID_MIN, W_SPREAD_MIN, W_SPREAD_MAX, W_SPREAD_SUM,
                                   W_PPS_SUM, W_BUY_VOL, W_SELL_VOL, W_SIZE_MIN,
                                   W_L1_SUM, W_TICK};
         foreach (sels[i]) begin
            add_row(blank_item(FUNC_READ_BIN, T_BASE, 8'd0, sels[i]), 1'b0, 65'd0);
         end
      end
      add_row(blank_item(FUNC_READ_DAY, T_BASE, 8'd0, W_TIMESTAMP), 1'b0, 65'd0);
      add_row(blank_item(FUNC_READ_DAY, T_BASE, 8'd7, W_SIZE_MAX), 1'b0, 65'd0);

      foreach (dir_items[i]) send_item(dir_items[i], dir_typed[i], dir_res[i]);

      for (int p = 0; p < 6; p++) begin
         drain_idle();
         write_window(17'(phase_ws[p]), 17'(phase_we[p]));
         send_idle_pct  = (phase_mode[p] == 1) ? 62 : (phase_mode[p] == 3) ? 8 : 0;
         recv_stall_pct = (phase_mode[p] == 2) ? 62 : (phase_mode[p] == 3) ? 8 : 0;
         // a read of minute zero before the window start is refused
         send_item(blank_item(FUNC_READ_BIN, 32'($urandom_range(49709)) * 32'd86400 +
                   32'(phase_ws[p]) - 32'd1, 8'd1, W_MSG_COUNT), 0, '0);
         for (int n = 0; n < 305; n++) send_item(random_item(), 0, '0);
      end
      drain_idle();

      $display("covered %0d counted-or-dropped quotes, %0d trades and %0d reads",
               n_quotes, n_trades, n_reads);
      $display("%0d responses checked over six window settings, %0d mismatches",
               checked, mismatches);
      if (mismatches == 0 && expected_reads.size() == 0) begin
         $display("market_minute_bar_statistics_tb OK");
      end else begin
         $display("market_minute_bar_statistics_tb NOT OK");
      end
      $finish;
   end

endmodule
